// ===== hw/rtl/lru_set_assoc_cache_sim_assert.svh =====
// Assertion macros for the LRU set-associative cache model block.
`ifndef LRU_SET_ASSOC_CACHE_SIM_ASSERT_SVH
`define LRU_SET_ASSOC_CACHE_SIM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSAC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lsac_pkg.sv =====
// Shared types and constants for the LRU set-associative cache model block.
`default_nettype none

package lsac_pkg;

	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;
	localparam int ADDR_WIDTH   = 64;

	localparam int NUM_SETS  = 1 << MAX_SET_BITS;
	localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int SB_W      = 4;   // holds an effective set-bit count up to 6
	localparam int SHIFT_W   = 7;   // set bits plus block bits, up to 69
	localparam int AGE_W     = 3;
	localparam int CNT_W     = 32;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	localparam logic [AGE_W-1:0] AGE_TOP = '1;

	// operation codes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_STORE  = 2'd1;
	localparam logic [1:0] OP_MODIFY = 2'd2;

	// outcome codes
	localparam logic [1:0] OUTCOME_HIT   = 2'd0;
	localparam logic [1:0] OUTCOME_MISS  = 2'd1;
	localparam logic [1:0] OUTCOME_EVICT = 2'd2;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS       = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] address;
	} req_t;

	typedef struct packed {
		logic [1:0]       outcome;
		logic             extra_hit;
		logic [CNT_W-1:0] hit_count;
		logic [CNT_W-1:0] miss_count;
		logic [CNT_W-1:0] eviction_count;
	} res_t;

	typedef struct packed {
		logic [2:0] set_bits;
		logic [5:0] block_bits;
		logic [3:0] ways_in_use;
	} cfg_t;

	// one set: all ways side by side
	typedef struct packed {
		logic [MAX_WAYS-1:0]                 valid;
		logic [MAX_WAYS-1:0][AGE_W-1:0]      age;
		logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
	} row_t;

	typedef struct packed {
		logic lookup;   // take the request, read its set
		logic commit;   // resolve, write the set back, launch the result
	} cmd_t;

	typedef struct packed {
		logic out_free; // output register can take a result this cycle
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lsac_regs.sv =====
// APB configuration registers: set bits, block bits, ways in use.
`default_nettype none

module lsac_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lsac_pkg::PADDR_W-1:0] paddr,
	input  wire logic [lsac_pkg::PDATA_W-1:0] pwdata,
	output logic      [lsac_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	output lsac_pkg::cfg_t                   cfg
);
	import lsac_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_bits    <= 3'd0;
			cfg_q.block_bits  <= 6'd0;
			cfg_q.ways_in_use <= 4'd1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SET_BITS:   cfg_q.set_bits    <= pwdata[2:0];
				REG_BLOCK_BITS: cfg_q.block_bits  <= pwdata[5:0];
				REG_WAYS:       cfg_q.ways_in_use <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SET_BITS:   prdata = PDATA_W'(cfg_q.set_bits);
			REG_BLOCK_BITS: prdata = PDATA_W'(cfg_q.block_bits);
			REG_WAYS:       prdata = PDATA_W'(cfg_q.ways_in_use);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lsac_ctrl.sv =====
// Controller: takes a request, then commits it once the output can take it.
`default_nettype none

module lsac_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [1:0] req_op,
	output logic            req_stall,
	input  lsac_pkg::status_t status,
	output lsac_pkg::cmd_t  cmd
);
	import lsac_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   op_real;

	assign op_real = (req_op == OP_LOAD) || (req_op == OP_STORE) || (req_op == OP_MODIFY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		req_stall  = 1'b1;
		cmd.lookup = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				// unknown operation is taken and dropped
				if (req_valid && op_real) begin
					cmd.lookup = 1'b1;
					state_nxt  = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lsac_dp.sv =====
// Datapath: set memory, hit/victim logic, LRU ages, totals, output register.
`default_nettype none

module lsac_dp (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  lsac_pkg::cfg_t    cfg,
	input  lsac_pkg::req_t    req_data,
	input  lsac_pkg::cmd_t    cmd,
	output lsac_pkg::status_t status,
	output logic              res_valid,
	input  wire logic         res_stall,
	output lsac_pkg::res_t    res_data
);
	import lsac_pkg::*;

	function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] c, logic [1:0] inc);
		logic [CNT_W:0] sum;
		sum = {1'b0, c} + (CNT_W+1)'(inc);
		return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
	endfunction

	// set memory and per-set live flags (a set never written reads as empty)
	row_t               mem [NUM_SETS];
	logic [NUM_SETS-1:0] row_live_q;

	// lookup stage
	logic [ADDR_WIDTH-1:0] addr_a;
	logic [SB_W-1:0]       eff_sb;
	logic [SHIFT_W-1:0]    shift;
	logic [SET_IDX_W-1:0]  set_idx;
	logic [ADDR_WIDTH-1:0] tag;

	row_t                  row_s1;
	logic                  live_s1;
	logic [SET_IDX_W-1:0]  set_s1;
	logic [ADDR_WIDTH-1:0] tag_s1;
	logic [1:0]            op_s1;

	// resolve stage
	logic [MAX_WAYS-1:0]            used;
	logic [MAX_WAYS-1:0]            vld;
	logic [MAX_WAYS-1:0][AGE_W-1:0] age_eff;
	logic [MAX_WAYS-1:0]            hit_vec;
	logic [MAX_WAYS-1:0]            empty_vec;
	logic                           hit;
	logic                           has_empty;
	logic [WAY_W-1:0]               hit_way;
	logic [WAY_W-1:0]               empty_way;
	logic [WAY_W-1:0]               victim;
	logic [AGE_W-1:0]               best;
	logic [WAY_W-1:0]               touch;
	logic [AGE_W:0]                 limit;
	row_t                           row_new;
	res_t                           res_nxt;
	logic [1:0]                     hit_inc;

	logic [CNT_W-1:0] hit_q;
	logic [CNT_W-1:0] miss_q;
	logic [CNT_W-1:0] evict_q;
	logic             res_valid_q;
	res_t             res_q;

	// address split
	always_comb begin
		addr_a  = req_data.address[ADDR_WIDTH-1:0];
		eff_sb  = (SB_W'(cfg.set_bits) > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
		                                                       : SB_W'(cfg.set_bits);
		shift   = SHIFT_W'(eff_sb) + SHIFT_W'(cfg.block_bits);
		set_idx = SET_IDX_W'(addr_a >> cfg.block_bits) & ~({SET_IDX_W{1'b1}} << eff_sb);
		tag     = addr_a >> shift;
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			row_s1  <= mem[set_idx];
			live_s1 <= row_live_q[set_idx];
			set_s1  <= set_idx;
			tag_s1  <= tag;
			op_s1   <= req_data.operation;
		end
		if (cmd.commit) begin
			mem[set_s1] <= row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_live_q <= '0;
		end else if (cmd.commit) begin
			row_live_q[set_s1] <= 1'b1;
		end
	end

	// hit / fill / victim selection over the ways of one set
	always_comb begin
		for (int v = 0; v < MAX_WAYS; v++) begin
			used[v]      = (v == 0) || (v < int'(cfg.ways_in_use));
			vld[v]       = live_s1 & row_s1.valid[v];
			age_eff[v]   = live_s1 ? row_s1.age[v] : '0;
			hit_vec[v]   = used[v] & vld[v] & (row_s1.tag[v] == tag_s1);
			empty_vec[v] = used[v] & ~vld[v];
		end
		hit       = |hit_vec;
		has_empty = |empty_vec;

		hit_way   = '0;
		empty_way = '0;
		for (int v = MAX_WAYS - 1; v >= 0; v--) begin
			if (hit_vec[v]) begin
				hit_way = WAY_W'(v);
			end
			if (empty_vec[v]) begin
				empty_way = WAY_W'(v);
			end
		end

		// oldest way, ties to the lowest index
		best   = age_eff[0];
		victim = '0;
		for (int v = 1; v < MAX_WAYS; v++) begin
			if (used[v] && vld[v] && (age_eff[v] > best)) begin
				best   = age_eff[v];
				victim = WAY_W'(v);
			end
		end

		touch = hit ? hit_way : (has_empty ? empty_way : victim);
		limit = hit ? {1'b0, age_eff[hit_way]} : {1'b1, {AGE_W{1'b0}}};

		row_new.tag   = row_s1.tag;
		row_new.valid = vld;
		for (int v = 0; v < MAX_WAYS; v++) begin
			if (WAY_W'(v) == touch) begin
				row_new.age[v]   = '0;
				row_new.valid[v] = 1'b1;
				row_new.tag[v]   = tag_s1;
			end else if (used[v] && vld[v] && ({1'b0, age_eff[v]} < limit)
			             && (age_eff[v] != AGE_TOP)) begin
				row_new.age[v] = age_eff[v] + AGE_W'(1);
			end else begin
				row_new.age[v] = age_eff[v];
			end
		end

		// a modify's store part always hits the line just touched
		hit_inc = {1'b0, hit} + {1'b0, op_s1 == OP_MODIFY};

		res_nxt.outcome        = hit ? OUTCOME_HIT : (has_empty ? OUTCOME_MISS : OUTCOME_EVICT);
		res_nxt.extra_hit      = (op_s1 == OP_MODIFY);
		res_nxt.hit_count      = sat_add(hit_q, hit_inc);
		res_nxt.miss_count     = sat_add(miss_q, {1'b0, ~hit});
		res_nxt.eviction_count = sat_add(evict_q, {1'b0, ~hit & ~has_empty});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= '0;
			miss_q  <= '0;
			evict_q <= '0;
		end else if (cmd.commit) begin
			hit_q   <= res_nxt.hit_count;
			miss_q  <= res_nxt.miss_count;
			evict_q <= res_nxt.eviction_count;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= res_nxt;
		end
	end

	assign status.out_free = ~res_valid_q | ~res_stall;
	assign res_valid       = res_valid_q;
	assign res_data        = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lru_set_assoc_cache_sim.sv =====
// Top level of the LRU set-associative cache model block.
//
//   channel   dir  handshake              payload
//   req       in   req_valid / req_stall  req_data  (operation, address)
//   res       out  res_valid / res_stall  res_data  (outcome, extra_hit, totals)
//   apb       in   psel/penable/pwrite    paddr, pwdata -> prdata, pready
//
// The accept cycle reads all ways of the request's set from the set memory into
// the lookup registers; the update state then resolves hit/victim and writes the set
// back. One request is in flight at a time; a new one is taken only after that write-back.
// Reset empties the cache at once through per-set live flags, no sweep.
// A held result does not block the next request's read; the write-back
// waits while the output register is full and stalled.
// An operation code of 3 is accepted and dropped without any result.
`default_nettype none
`include "lru_set_assoc_cache_sim_assert.svh"

module lru_set_assoc_cache_sim (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// request channel
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  lsac_pkg::req_t                    req_data,
	// result channel
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output lsac_pkg::res_t                    res_data,
	// configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lsac_pkg::PADDR_W-1:0] paddr,
	input  wire logic [lsac_pkg::PDATA_W-1:0] pwdata,
	output logic      [lsac_pkg::PDATA_W-1:0] prdata,
	output logic                              pready
);
	import lsac_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	lsac_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencing: idle -> update
	lsac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req_data.operation),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// set memory, replacement logic, totals and output register
	lsac_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_data  (req_data),
		.cmd       (cmd),
		.status    (status),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// a real request always moves the controller out of idle
	`LSAC_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall && (req_data.operation == OP_LOAD || req_data.operation == OP_STORE || req_data.operation == OP_MODIFY), req_stall, "request accepted but block not busy")

	// every commit lands in the output register
	`LSAC_ASSERT_NEXT(a_commit_res, cmd.commit, res_valid, "commit without a result")

	// an eviction result always carries a nonzero eviction total
	`LSAC_ASSERT_NEXT(a_evict_count, cmd.commit, res_data.outcome != OUTCOME_EVICT || res_data.eviction_count != '0, "eviction with zero eviction total")

endmodule

`default_nettype wire

// ===== tb/lsac_tracker.sv =====
// Cache access tracker: predicts each result from the accepted requests and checks the block.
module lsac_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_stall,
	input  lsac_pkg::req_t               req_data,
	input  logic                         res_valid,
	input  logic                         res_stall,
	input  lsac_pkg::res_t               res_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [lsac_pkg::PADDR_W-1:0] paddr,
	input  logic [lsac_pkg::PDATA_W-1:0] pwdata,
	output int                           fails,
	output int                           pending
);
	import lsac_pkg::*;

	localparam int LINES = NUM_SETS * MAX_WAYS;

	// geometry as last written over the register port
	logic [2:0] sel_bits = '0;
	logic [5:0] ofs_bits = '0;
	logic [3:0] assoc    = 4'd1;

	// line (set, way) lives at set * MAX_WAYS + way
	logic                  vld_mem [LINES];
	logic [ADDR_WIDTH-1:0] tag_mem [LINES];
	logic [AGE_W-1:0]      age_mem [LINES];
	logic [CNT_W-1:0]      n_hit   = '0;
	logic [CNT_W-1:0]      n_miss  = '0;
	logic [CNT_W-1:0]      n_evict = '0;

	res_t due_q [$];
	int   n_bad  = 0;
	int   n_seen = 0;

	initial begin
		for (int i = 0; i < LINES; i++) begin
			vld_mem[i] = 1'b0;
			tag_mem[i] = '0;
			age_mem[i] = '0;
		end
	end

	function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// valid ways other than hot, with age below limit, grow older; hot becomes youngest
	function automatic void refresh_ages(input int base, input int nw, input int hot,
			input int limit);
		for (int v = 0; v < nw; v++) begin
			if (v != hot && vld_mem[base+v] && age_mem[base+v] < limit
					&& age_mem[base+v] != AGE_TOP)
				age_mem[base+v] = age_mem[base+v] + 1'b1;
		end
		age_mem[base+hot] = '0;
	endfunction

	// one lookup/fill, returns the outcome code
	function automatic logic [1:0] probe_line(input logic [ADDR_WIDTH-1:0] addr);
		int                    sb;
		int                    bb;
		int                    nw;
		int                    base;
		int                    spill;
		int                    empty;
		logic [AGE_W-1:0]      oldest;
		logic [ADDR_WIDTH-1:0] set_idx;
		logic [ADDR_WIDTH-1:0] tg;
		sb = (sel_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(sel_bits);
		bb = int'(ofs_bits);
		nw = (assoc == 0) ? 1 : (assoc > MAX_WAYS) ? MAX_WAYS : int'(assoc);
		set_idx = (addr >> bb) & ((64'd1 << sb) - 64'd1);
		tg = (sb + bb >= ADDR_WIDTH) ? '0 : (addr >> (sb + bb));
		base = int'(set_idx) * MAX_WAYS;
		for (int w = 0; w < nw; w++) begin
			if (vld_mem[base+w] && tag_mem[base+w] == tg) begin
				refresh_ages(base, nw, w, int'(age_mem[base+w]));
				n_hit = sat_up(n_hit);
				return OUTCOME_HIT;
			end
		end
		n_miss = sat_up(n_miss);
		empty  = -1;
		spill  = 0;
		oldest = '0;
		for (int w = 0; w < nw; w++) begin
			if (!vld_mem[base+w]) begin
				if (empty < 0)
					empty = w;
			end else if (age_mem[base+w] > oldest) begin
				oldest = age_mem[base+w];
				spill  = w;
			end
		end
		if (empty >= 0) begin
			vld_mem[base+empty] = 1'b1;
			tag_mem[base+empty] = tg;
			refresh_ages(base, nw, empty, int'(AGE_TOP) + 1);
			return OUTCOME_MISS;
		end
		tag_mem[base+spill] = tg;
		refresh_ages(base, nw, spill, int'(AGE_TOP) + 1);
		n_evict = sat_up(n_evict);
		return OUTCOME_EVICT;
	endfunction

	function automatic res_t predict_request(input req_t r);
		res_t e;
		e.outcome   = probe_line(r.address);
		e.extra_hit = 1'b0;
		if (r.operation == OP_MODIFY) begin
			void'(probe_line(r.address));   // store half of a modify
			e.extra_hit = 1'b1;
		end
		e.hit_count      = n_hit;
		e.miss_count     = n_miss;
		e.eviction_count = n_evict;
		return e;
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SET_BITS:   sel_bits = pwdata[2:0];
					REG_BLOCK_BITS: ofs_bits = pwdata[5:0];
					REG_WAYS:       assoc    = pwdata[3:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall && (req_data.operation == OP_LOAD
					|| req_data.operation == OP_STORE || req_data.operation == OP_MODIFY))
				due_q.push_back(predict_request(req_data));
			if (res_valid && !res_stall) begin
				if (due_q.size() == 0) begin
					if (n_bad < 10)
						$display("result %0d arrived with nothing expected: %h", n_seen, res_data);
					n_bad++;
				end else begin
					want = due_q.pop_front();
					if (res_data.outcome !== want.outcome
							|| res_data.extra_hit !== want.extra_hit
							|| res_data.hit_count !== want.hit_count
							|| res_data.miss_count !== want.miss_count
							|| res_data.eviction_count !== want.eviction_count) begin
						if (n_bad < 10)
							$display({"result %0d: expected outcome %0d extra %0b hit %0d",
								" miss %0d evict %0d, got outcome %0d extra %0b hit %0d",
								" miss %0d evict %0d"}, n_seen,
								want.outcome, want.extra_hit, want.hit_count,
								want.miss_count, want.eviction_count,
								res_data.outcome, res_data.extra_hit, res_data.hit_count,
								res_data.miss_count, res_data.eviction_count);
						n_bad++;
					end
				end
				n_seen++;
			end
		end
		fails   <= n_bad;
		pending <= due_q.size();
	end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the LRU set-associative cache block.
module tb_top;
	import lsac_pkg::*;

	// operation code the block accepts and drops
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam int PER_PHASE   = 64;       // counted requests per random phase
	localparam int PHASES      = 12;
	localparam int SETTLE      = 12;       // quiet cycles after the last result
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req_data  = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res_data;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [PADDR_W-1:0]   paddr     = '0;
	logic [PDATA_W-1:0]   pwdata    = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	int fails;
	int pending;
	int cycles = 0;

	// calm phases run with no gaps on either side
	bit calm = 1'b0;

	// effective geometry of the current phase; only used to aim addresses
	int sb_now   = 0;
	int bb_now   = 0;
	int ways_now = 1;

	// tags reused across phases, so lines kept through a way-count change get hit again
	logic [63:0] tag_pool [16];

	// random-phase geometries: set bits, block bits, ways; the last two are drawn at random.
	// They cover the reset geometry's opposite corners, oversized set bits, zero ways,
	// too many ways, a shift of 64 and more (tag zero), and a way count that drops
	// to 2 and comes back to 8 without a flush.
	int plan_sb   [PHASES] = '{6, 7, 0, 3, 6, 6, 6, 1, 2, 5, 0, 0};
	int plan_bb   [PHASES] = '{32, 63, 0, 5, 58, 32, 32, 1, 40, 27, 0, 0};
	int plan_ways [PHASES] = '{8, 15, 0, 9, 8, 2, 8, 3, 5, 12, 0, 0};

	lru_set_assoc_cache_sim dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	lsac_tracker watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// result side: alternate runs of taking and stalling
	initial begin
		int run_left;
		bit hold;
		run_left = 0;
		hold     = 1'b0;
		forever begin
			@(posedge clk);
			if (run_left == 0) begin
				hold     = !calm && ($urandom_range(0, 2) == 0);
				run_left = hold ? 1 + gap_len() : $urandom_range(1, 8);
			end
			run_left--;
			res_stall <= hold;
		end
	end

	// present one request and hold it until taken; valid stays up for the next one
	task automatic put_req(input logic [1:0] op, input logic [63:0] addr);
		req_t r;
		int   gap;
		r.operation = op;
		r.address   = addr;
		gap = gap_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// setup cycle, then access cycle; pready ends it; the bus then goes idle before the task returns
	task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= ({$urandom} << 8) | {26'd0, val};   // bits above the field are ignored
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid, wait for every expected result, then let a dropped request finish
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_geometry(input int sb, input int bb, input int ways, input bit quiet);
		settle();
		write_reg(REG_SET_BITS, 6'(sb));
		write_reg(REG_BLOCK_BITS, 6'(bb));
		write_reg(REG_WAYS, 6'(ways));
		sb_now   = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
		bb_now   = bb;
		ways_now = (ways == 0) ? 1 : (ways > MAX_WAYS) ? MAX_WAYS : ways;
		calm     = quiet;
	endtask

	// mostly addresses built from pooled tags on a few sets, so hits, fills and
	// evictions all happen; some fully random addresses and fresh tags as noise
	function automatic logic [63:0] shape_addr();
		int          r;
		int          sh;
		int          top;
		logic [63:0] tg;
		logic [63:0] set_part;
		logic [63:0] ofs;
		r = $urandom_range(0, 99);
		if (r < 8)
			return {$urandom, $urandom};
		top = (ways_now + 2 > 15) ? 15 : ways_now + 2;
		tg  = (r < 16) ? {$urandom, $urandom} : tag_pool[$urandom_range(0, top)];
		sh  = sb_now + bb_now;
		set_part = (r < 60) ? 64'($urandom_range(0, 3)) : 64'($urandom);
		set_part = set_part & ((64'd1 << sb_now) - 64'd1);
		ofs      = {$urandom, $urandom} & ((64'd1 << bb_now) - 64'd1);
		return ((sh >= 64) ? 64'd0 : (tg << sh)) | (set_part << bb_now) | ofs;
	endfunction

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return OP_UNKNOWN;
		if (r < 38)
			return OP_LOAD;
		if (r < 68)
			return OP_STORE;
		return OP_MODIFY;
	endfunction

	// dropped requests don't count toward the phase
	task automatic run_phase(input int n);
		int         done;
		logic [1:0] op;
		done = 0;
		while (done < n) begin
			op = pick_op();
			put_req(op, shape_addr());
			if (op != OP_UNKNOWN)
				done++;
		end
	endtask

	initial begin
		for (int i = 0; i < 16; i++)
			tag_pool[i] = {$urandom, $urandom};
		tag_pool[0] = '0;
		tag_pool[1] = '1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry is one set of one way: every new tag evicts
		put_req(OP_LOAD, 64'd0);                         // cold miss
		put_req(OP_LOAD, 64'd0);                         // hit
		put_req(OP_STORE, '1);                           // eviction
		put_req(OP_MODIFY, '1);                          // hit, store half hits too
		put_req(OP_MODIFY, 64'h5555_5555_5555_5555);     // eviction plus the store hit
		put_req(OP_UNKNOWN, 64'h0123_4567_89ab_cdef);    // dropped, no result
		put_req(OP_STORE, 64'haaaa_aaaa_aaaa_aaaa);
		put_req(OP_LOAD, 64'h8000_0000_0000_0001);

		// 2 sets of 8 ways, 8-byte blocks; work set 1
		set_geometry(1, 3, 8, 1'b0);
		for (int t = 0; t < 8; t++)
			put_req(OP_LOAD, (64'(t) << 4) | 64'h8 | 64'h5);     // fill the set
		put_req(OP_LOAD, (64'd8 << 4) | 64'h8);          // oldest way goes out
		put_req(OP_MODIFY, (64'd1 << 4) | 64'h8);        // hit on a way whose age is pinned
		put_req(OP_STORE, (64'd0 << 4) | 64'h8);         // way 2 alone has the top age and goes out
		put_req(OP_LOAD, (64'd5 << 4) | 64'h8);          // hit in the middle of the order
		put_req(OP_STORE, (64'd3 << 4));                 // other set, cold miss

		for (int p = 0; p < PHASES; p++) begin
			if (p >= PHASES - 2) begin
				plan_sb[p]   = $urandom_range(0, 7);
				plan_bb[p]   = $urandom_range(0, 63);
				plan_ways[p] = $urandom_range(0, 15);
			end
			set_geometry(plan_sb[p], plan_bb[p], plan_ways[p], (p % 4) == 3);
			run_phase(PER_PHASE);
		end

		settle();
		if (fails == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
